// ----- rtl/tlb_page_table_translation_macros.svh -----
// Assertion macros used by the checker file of the translation block.
`ifndef TLB_PAGE_TABLE_TRANSLATION_MACROS_SVH
`define TLB_PAGE_TABLE_TRANSLATION_MACROS_SVH

// Plain property, clocked and disabled during reset.
`define TLB_PTT_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tlb_ptt assertion failed");

// Same-cycle implication.
`define TLB_PTT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlb_ptt implication failed");

// Next-cycle implication.
`define TLB_PTT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlb_ptt next-cycle implication failed");

`endif

// ----- rtl/tlb_ptt_pkg.sv -----
// Package: sizes, constants and interface structs of the translation block.
package tlb_ptt_pkg;

  localparam int TLB_ENTRIES = 16;
  localparam int PAGE_BITS   = 8;
  localparam int OFFSET_BITS = 8;
  localparam int ADDR_W      = 16;
  localparam int COUNT_W     = 16;
  localparam int NUM_PAGES   = 1 << PAGE_BITS;
  localparam int FREE_W      = PAGE_BITS + 1;
  localparam int PHYS_W      = (PAGE_BITS + OFFSET_BITS > ADDR_W) ?
                               (PAGE_BITS + OFFSET_BITS) : ADDR_W;

  typedef logic [PAGE_BITS-1:0]   page_t;
  typedef logic [PAGE_BITS-1:0]   frame_t;
  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [COUNT_W-1:0]     count_t;

  // TLB insert request and lookup result
  typedef struct packed {
    logic   en;
    page_t  page;
    frame_t frame;
  } cam_ins_t;

  typedef struct packed {
    logic   hit;
    frame_t frame;
  } cam_res_t;

  // Page table access and registered read data
  typedef struct packed {
    logic   rd_en;
    logic   wr_en;
    page_t  page;
    frame_t frame;
  } tbl_req_t;

  typedef struct packed {
    logic   valid;
    frame_t frame;
  } tbl_rsp_t;

endpackage

// ----- rtl/tlb_ptt_if.sv -----
// Valid/ready channel interfaces for address requests and translation results.
interface tlb_ptt_req_if;
  logic                 valid;
  logic                 ready;
  tlb_ptt_pkg::addr_t   logical_address;

  modport source (output valid, output logical_address, input ready);
  modport sink (input valid, input logical_address, output ready);
endinterface

interface tlb_ptt_rsp_if;
  logic                 valid;
  logic                 ready;
  tlb_ptt_pkg::addr_t   physical_address;
  logic                 tlb_hit;
  logic                 page_fault;
  tlb_ptt_pkg::count_t  hit_count;
  tlb_ptt_pkg::count_t  fault_count;

  modport source (output valid, output physical_address, output tlb_hit,
                  output page_fault, output hit_count, output fault_count,
                  input ready);
  modport sink (input valid, input physical_address, input tlb_hit,
                input page_fault, input hit_count, input fault_count,
                output ready);
endinterface

// ----- rtl/tlb_ptt_cam.sv -----
// TLB: shift-register entries with parallel page compare, FIFO insert at entry 0.
module tlb_ptt_cam (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tlb_ptt_pkg::page_t    page_i,
  input  tlb_ptt_pkg::cam_ins_t ins_i,
  output tlb_ptt_pkg::cam_res_t res_o
);

  tlb_ptt_pkg::page_t  page_q  [tlb_ptt_pkg::TLB_ENTRIES];
  tlb_ptt_pkg::frame_t frame_q [tlb_ptt_pkg::TLB_ENTRIES];
  logic [tlb_ptt_pkg::TLB_ENTRIES-1:0] valid_q;

  // lowest matching entry wins: scan from the top, lower entries override
  always_comb begin
    res_o = '0;
    for (int i = tlb_ptt_pkg::TLB_ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && (page_q[i] == page_i)) begin
        res_o.hit   = 1'b1;
        res_o.frame = frame_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < tlb_ptt_pkg::TLB_ENTRIES; i++) begin
        page_q[i]  <= '0;
        frame_q[i] <= '0;
      end
    end else if (ins_i.en) begin
      for (int i = tlb_ptt_pkg::TLB_ENTRIES - 1; i > 0; i--) begin
        page_q[i]  <= page_q[i-1];
        frame_q[i] <= frame_q[i-1];
        valid_q[i] <= valid_q[i-1];
      end
      page_q[0]  <= ins_i.page;
      frame_q[0] <= ins_i.frame;
      valid_q[0] <= 1'b1;
    end
  end

endmodule

// ----- rtl/tlb_ptt_page_table.sv -----
// Page table: frame RAM with registered read data plus per-page valid flops.
module tlb_ptt_page_table (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tlb_ptt_pkg::tbl_req_t req_i,
  output tlb_ptt_pkg::tbl_rsp_t rsp_o
);

  tlb_ptt_pkg::frame_t frame_mem [tlb_ptt_pkg::NUM_PAGES];
  logic [tlb_ptt_pkg::NUM_PAGES-1:0] valid_q;
  logic                rd_valid_q;
  tlb_ptt_pkg::frame_t rd_frame_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      frame_mem[req_i.page] <= req_i.frame;
    end
    if (req_i.rd_en) begin
      rd_frame_q <= frame_mem[req_i.page];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[req_i.page] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.page];
      end
    end
  end

  assign rsp_o.valid = rd_valid_q;
  assign rsp_o.frame = rd_frame_q;

endmodule

// ----- rtl/tlb_page_table_translation.sv -----
// Translates a logical address to a physical one. A request is taken, its page is
// compared against all TLB entries in the next cycle while the page table RAM is
// read, and in the cycle after that the frame is resolved (TLB hit, table entry,
// or a newly allocated frame on a page fault), the TLB is updated on a miss, the
// page table on a fault, and the result is registered. A new request can be taken
// in the same resolve cycle, when the output is free; the lookup cycle runs the TLB
// compare alongside the registered page table RAM read. A held result stalls the
// resolve step until it is taken. No clearing pass runs after reset: page table
// entries carry valid flops.
module tlb_page_table_translation (
  input  logic          clk_i,
  input  logic          rst_ni,
  tlb_ptt_req_if.sink   req_i,
  tlb_ptt_rsp_if.source rsp_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_RESOLVE
  } state_e;

  state_e                state_q, state_d;
  tlb_ptt_pkg::page_t    page_q;
  tlb_ptt_pkg::offset_t  offset_q;
  logic                  hit_q;
  tlb_ptt_pkg::frame_t   tlb_frame_q;
  logic [tlb_ptt_pkg::FREE_W-1:0] next_free_q;
  tlb_ptt_pkg::count_t   hits_q, faults_q;

  logic                  rsp_valid_q;
  tlb_ptt_pkg::addr_t    phys_q;
  logic                  rsp_hit_q, rsp_fault_q;

  tlb_ptt_pkg::cam_ins_t cam_ins;
  tlb_ptt_pkg::cam_res_t cam_res;
  tlb_ptt_pkg::tbl_req_t tbl_req;
  tlb_ptt_pkg::tbl_rsp_t tbl_rsp;

  logic                  out_free, accept, fire, fault;
  tlb_ptt_pkg::frame_t   frame;
  logic [tlb_ptt_pkg::PHYS_W-1:0] addr_ext, phys_full;

  assign out_free    = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE) || ((state_q == ST_RESOLVE) && out_free);
  assign accept      = req_i.valid && req_i.ready;
  assign fire        = (state_q == ST_RESOLVE) && out_free;

  assign addr_ext = tlb_ptt_pkg::PHYS_W'(req_i.logical_address);

  assign fault = !hit_q && !tbl_rsp.valid;
  always_comb begin
    priority if (hit_q)     frame = tlb_frame_q;
    else if (tbl_rsp.valid) frame = tbl_rsp.frame;
    else                    frame = next_free_q[tlb_ptt_pkg::PAGE_BITS-1:0];
  end
  assign phys_full = tlb_ptt_pkg::PHYS_W'({frame, offset_q});

  assign cam_ins.en    = fire && !hit_q;
  assign cam_ins.page  = page_q;
  assign cam_ins.frame = frame;

  assign tbl_req.rd_en = (state_q == ST_LOOKUP);
  assign tbl_req.wr_en = fire && fault;
  assign tbl_req.page  = page_q;
  assign tbl_req.frame = frame;

  tlb_ptt_cam u_cam (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .page_i (page_q),
    .ins_i  (cam_ins),
    .res_o  (cam_res)
  );

  tlb_ptt_page_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tbl_req),
    .rsp_o  (tbl_rsp)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (accept) state_d = ST_LOOKUP;
      ST_LOOKUP:  state_d = ST_RESOLVE;
      ST_RESOLVE: if (fire) state_d = accept ? ST_LOOKUP : ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      page_q      <= '0;
      offset_q    <= '0;
      hit_q       <= 1'b0;
      tlb_frame_q <= '0;
      next_free_q <= '0;
      hits_q      <= '0;
      faults_q    <= '0;
      rsp_valid_q <= 1'b0;
      phys_q      <= '0;
      rsp_hit_q   <= 1'b0;
      rsp_fault_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        page_q   <= addr_ext[tlb_ptt_pkg::OFFSET_BITS +: tlb_ptt_pkg::PAGE_BITS];
        offset_q <= addr_ext[tlb_ptt_pkg::OFFSET_BITS-1:0];
      end
      if (state_q == ST_LOOKUP) begin
        hit_q       <= cam_res.hit;
        tlb_frame_q <= cam_res.frame;
      end
      if (fire) begin
        if (hit_q && (hits_q != '1)) begin
          hits_q <= hits_q + 1'b1;
        end
        if (fault) begin
          if (faults_q != '1) faults_q <= faults_q + 1'b1;
          if (next_free_q != tlb_ptt_pkg::FREE_W'(tlb_ptt_pkg::NUM_PAGES)) begin
            next_free_q <= next_free_q + 1'b1;
          end
        end
        rsp_valid_q <= 1'b1;
        phys_q      <= phys_full[tlb_ptt_pkg::ADDR_W-1:0];
        rsp_hit_q   <= hit_q;
        rsp_fault_q <= fault;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // counters are registered with the result, so they already include this request
  assign rsp_o.valid            = rsp_valid_q;
  assign rsp_o.physical_address = phys_q;
  assign rsp_o.tlb_hit          = rsp_hit_q;
  assign rsp_o.page_fault       = rsp_fault_q;
  assign rsp_o.hit_count        = hits_q;
  assign rsp_o.fault_count      = faults_q;

endmodule

// ----- rtl/tlb_ptt_checker.sv -----
// Port-level checks of the translation block, bound to the top level.
`include "tlb_page_table_translation_macros.svh"

module tlb_ptt_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_ready_i,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input tlb_ptt_pkg::addr_t  physical_address_i,
  input logic                tlb_hit_i,
  input logic                page_fault_i,
  input tlb_ptt_pkg::count_t hit_count_i,
  input tlb_ptt_pkg::count_t fault_count_i
);

  `TLB_PTT_ASSERT_IMP(a_hit_excl_fault, clk_i, rst_ni, rsp_valid_i, !(tlb_hit_i && page_fault_i))
  `TLB_PTT_ASSERT_IMP(a_hit_counted, clk_i, rst_ni, rsp_valid_i && tlb_hit_i, hit_count_i != '0)
  `TLB_PTT_ASSERT_IMP(a_fault_counted, clk_i, rst_ni, rsp_valid_i && page_fault_i, fault_count_i != '0)
  `TLB_PTT_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i)
  `TLB_PTT_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(physical_address_i))

endmodule

bind tlb_page_table_translation tlb_ptt_checker u_tlb_ptt_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .req_valid_i        (req_i.valid),
  .req_ready_i        (req_i.ready),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .physical_address_i (rsp_o.physical_address),
  .tlb_hit_i          (rsp_o.tlb_hit),
  .page_fault_i       (rsp_o.page_fault),
  .hit_count_i        (rsp_o.hit_count),
  .fault_count_i      (rsp_o.fault_count)
);
